@@ design/fdec_pkg.sv @@
// Shared types and constants of the form field decoder.
package fdec_pkg;

    localparam int GROUP_SLOTS = 3;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam logic [1:0] REG_KEY_CHARS  = 2'd0;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] REG_OUT_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_FOUND  = 2'd1,
        KIND_ABSENT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [63:0] key_chars;
        logic [3:0]  key_length;
        logic [7:0]  out_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                   count;
        t_kind [GROUP_SLOTS-1:0]      kind;
        logic [GROUP_SLOTS-1:0][7:0]  data;
    } t_group;

endpackage

@@ design/fdec_step.sv @@
// Per-byte parse state and the combinational step that forms each result group.
module fdec_step #(
    parameter int KEY_MAX_CHARS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [7:0]           i_byte,
    input  logic                 i_eob,
    input  fdec_pkg::t_cfg       i_cfg,
    output fdec_pkg::t_group     o_group
);

    typedef enum logic [1:0] {
        PH_MATCH = 2'd0,
        PH_SKIP  = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_kpos, n_kpos;
    logic [1:0]  r_pcnt, n_pcnt;
    logic [7:0]  r_pbyte, n_pbyte;
    logic [7:0]  r_ecnt, n_ecnt;

    function automatic logic f_full(logic [7:0] cnt, logic [7:0] lim);
        return ({1'b0, cnt} + 9'd1) >= {1'b0, lim};
    endfunction

    function automatic logic [4:0] f_hex(logic [7:0] c);
        logic [4:0] h;
        h = fdec_pkg::HEX_NONE;
        if (c inside {[8'h30:8'h39]}) h = 5'(c - 8'h30);
        else if (c inside {[8'h61:8'h66]}) h = 5'(c - 8'h57);
        else if (c inside {[8'h41:8'h46]}) h = 5'(c - 8'h37);
        return h;
    endfunction

    function automatic logic [7:0] f_plain(logic [7:0] c);
        return (c == fdec_pkg::CH_PLUS) ? fdec_pkg::CH_SPACE : c;
    endfunction

    function automatic logic [7:0] f_pct(logic [7:0] a, logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] v;
        ha = f_hex(a);
        hb = f_hex(b);
        v  = 8'd0;
        if (ha != fdec_pkg::HEX_NONE) begin
            v = (hb != fdec_pkg::HEX_NONE) ? {ha[3:0], hb[3:0]} : {4'h0, ha[3:0]};
        end else if (a inside {fdec_pkg::CH_SPACE, [8'h09:8'h0D], fdec_pkg::CH_PLUS}) begin
            v = (hb != fdec_pkg::HEX_NONE) ? {4'h0, hb[3:0]} : 8'd0;
        end else if (a == fdec_pkg::CH_MINUS) begin
            v = (hb != fdec_pkg::HEX_NONE) ? 8'd0 - {4'h0, hb[3:0]} : 8'd0;
        end
        return v;
    endfunction

    logic [3:0]  klen;
    logic [7:0]  key_byte;
    logic [7:0]  ec;
    logic [7:0]  ec_step;
    logic [1:0]  vn;
    logic [7:0]  v0, v1;
    logic        found, absent, term;
    logic        e0, e1;
    fdec_pkg::t_kind term_kind;

    assign klen = (i_cfg.key_length > 4'(KEY_MAX_CHARS)) ? 4'(KEY_MAX_CHARS) : i_cfg.key_length;
    assign key_byte = i_cfg.key_chars[{r_kpos[2:0], 3'b000} +: 8];

    always_comb begin
        n_phase = r_phase;
        n_kpos  = r_kpos;
        n_pcnt  = r_pcnt;
        n_pbyte = r_pbyte;
        ec      = r_ecnt;
        vn      = 2'd0;
        v0      = 8'd0;
        v1      = 8'd0;
        found   = 1'b0;
        absent  = 1'b0;
        case (r_phase)
            PH_MATCH: begin
                if (i_byte == fdec_pkg::CH_AMP) begin
                    n_kpos = 4'd0;
                end else if (r_kpos < klen) begin
                    if (i_byte == key_byte) n_kpos = r_kpos + 4'd1;
                    else n_phase = PH_SKIP;
                end else if (i_byte == fdec_pkg::CH_EQ) begin
                    n_phase = PH_VALUE;
                    ec      = 8'd0;
                    n_pcnt  = 2'd0;
                    if (f_full(8'd0, i_cfg.out_limit)) begin
                        found   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (i_byte == fdec_pkg::CH_AMP) begin
                    n_phase = PH_MATCH;
                    n_kpos  = 4'd0;
                end
            end
            PH_VALUE: begin
                if (i_byte == fdec_pkg::CH_AMP) begin
                    vn      = r_pcnt;
                    v0      = fdec_pkg::CH_PCT;
                    v1      = f_plain(r_pbyte);
                    found   = 1'b1;
                    n_phase = PH_DONE;
                    n_pcnt  = 2'd0;
                end else begin
                    case (r_pcnt)
                        2'd0: begin
                            if (i_byte == fdec_pkg::CH_PCT) begin
                                n_pcnt = 2'd1;
                            end else begin
                                vn = 2'd1;
                                v0 = f_plain(i_byte);
                            end
                        end
                        2'd1: begin
                            n_pcnt  = 2'd2;
                            n_pbyte = i_byte;
                        end
                        default: begin
                            vn     = 2'd1;
                            v0     = f_pct(r_pbyte, i_byte);
                            n_pcnt = 2'd0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        ec_step = ec + 8'((vn == 2'd1) && !f_full(ec, i_cfg.out_limit));
        if (n_phase == PH_VALUE && f_full(ec_step, i_cfg.out_limit)) begin
            found   = 1'b1;
            n_phase = PH_DONE;
            n_pcnt  = 2'd0;
        end

        if (i_eob) begin
            if (n_phase == PH_VALUE) begin
                if (n_pcnt != 2'd0) begin
                    vn = n_pcnt;
                    v0 = fdec_pkg::CH_PCT;
                    v1 = f_plain(n_pbyte);
                end
                found = 1'b1;
            end else if (n_phase != PH_DONE) begin
                absent = 1'b1;
            end
        end

        e0     = (vn != 2'd0) && !f_full(ec, i_cfg.out_limit);
        e1     = (vn == 2'd2) && e0 && !f_full(ec + 8'd1, i_cfg.out_limit);
        n_ecnt = ec + 8'(e0) + 8'(e1);

        if (i_eob) begin
            n_phase = PH_MATCH;
            n_kpos  = 4'd0;
            n_pcnt  = 2'd0;
            n_ecnt  = 8'd0;
        end
    end

    assign term      = found | absent;
    assign term_kind = found ? fdec_pkg::KIND_FOUND : fdec_pkg::KIND_ABSENT;

    always_comb begin
        o_group.count = 2'(e0) + 2'(e1) + 2'(term);
        o_group.kind  = {fdec_pkg::KIND_VALUE, fdec_pkg::KIND_VALUE, fdec_pkg::KIND_VALUE};
        o_group.data  = '0;
        if (e0) begin
            o_group.data[0] = v0;
            if (e1) begin
                o_group.data[1] = v1;
                o_group.kind[2] = term_kind;
            end else begin
                o_group.kind[1] = term_kind;
            end
        end else begin
            o_group.kind[0] = term_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MATCH;
            r_kpos  <= 4'd0;
            r_pcnt  <= 2'd0;
            r_ecnt  <= 8'd0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_kpos  <= n_kpos;
            r_pcnt  <= n_pcnt;
            r_ecnt  <= n_ecnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pbyte <= n_pbyte;
        end
    end

endmodule

@@ design/fdec_out.sv @@
// Result register that holds one group and hands it out one beat at a time.
module fdec_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fdec_pkg::t_group   i_group,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output fdec_pkg::t_kind    o_kind,
    output logic [7:0]         o_data,
    output logic               o_last
);

    logic [1:0]                                  r_count;
    fdec_pkg::t_kind [fdec_pkg::GROUP_SLOTS-1:0] r_kind;
    logic [fdec_pkg::GROUP_SLOTS-1:0][7:0]       r_data;
    logic                                        beat;

    assign o_valid = (r_count != 2'd0);
    assign beat    = o_valid && !i_stall;
    assign o_ready = (r_count == 2'd0) || (beat && r_count == 2'd1);
    assign o_kind  = r_kind[0];
    assign o_data  = r_data[0];
    assign o_last  = (r_count == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_load) begin
            r_count <= i_group.count;
        end else if (beat) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_group.kind;
            r_data <= i_group.data;
        end else if (beat) begin
            r_kind[0] <= r_kind[1];
            r_kind[1] <= r_kind[2];
            r_data[0] <= r_data[1];
            r_data[1] <= r_data[2];
        end
    end

endmodule

@@ design/form_field_url_decoder_unit.sv @@
// Top level of the form field decoder: input register, configuration and result path.
//
// Feed the form body on the input channel, one byte per beat, with
// i_end_of_body high on the final byte. A beat is taken when i_in_valid is
// high and o_in_stall is low. Results leave on the output channel, one per
// beat, taken when o_out_valid is high and i_out_stall is low: value bytes
// (kind 0) and then one done result (kind 1 found, kind 2 absent), with
// o_result_last marking the final result of each input byte.
// A byte passes an input register and then a result register that holds up
// to three results; its first result shows once the result register has
// loaded it, and the load waits until the last earlier result is taken.
// One byte is taken per cycle while each byte yields at most one result and the receiver does not stall.
// A byte yielding two or three results (such as a terminator flushing a held
// '%') keeps the result register until they are all taken, and input stalls meanwhile.
// When the receiver stalls, the result register holds and the input
// register fills, then o_in_stall rises.
// Write registers on the cfg channel only while the block is idle; it is
// always ready. Reset clears the parse state, empties both registers and
// loads key_chars 0, key_length 4 and out_limit 32.
module form_field_url_decoder_unit #(
    parameter int KEY_MAX_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_body,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_result_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    fdec_pkg::t_cfg   r_cfg;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eob;
    logic             grp_ready;
    logic             adv;
    fdec_pkg::t_group group;
    fdec_pkg::t_kind  out_kind;

    assign o_cfg_ready = 1'b1;
    assign adv         = r_in_valid && grp_ready;
    assign o_in_stall  = r_in_valid && !grp_ready;
    assign o_kind      = out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_chars  <= 64'd0;
            r_cfg.key_length <= 4'd4;
            r_cfg.out_limit  <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fdec_pkg::REG_KEY_CHARS:  r_cfg.key_chars  <= i_cfg_data;
                fdec_pkg::REG_KEY_LENGTH: r_cfg.key_length <= i_cfg_data[3:0];
                fdec_pkg::REG_OUT_LIMIT:  r_cfg.out_limit  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_eob  <= i_end_of_body;
        end
    end

    fdec_step #(
        .KEY_MAX_CHARS(KEY_MAX_CHARS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .i_cfg   (r_cfg),
        .o_group (group)
    );

    fdec_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && group.count != 2'd0),
        .i_group (group),
        .o_ready (grp_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_kind  (out_kind),
        .o_data  (o_out_byte),
        .o_last  (o_result_last)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && out_kind != fdec_pkg::KIND_VALUE |-> o_result_last)
        else $error("done result not last of its group");

    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && out_kind != fdec_pkg::KIND_VALUE |-> o_out_byte == 8'd0)
        else $error("done result carries a byte");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with result register empty");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the form field decoder: directed and random form bodies.
`timescale 1ns / 1ps

module tb;

    localparam int KEY_MAX_CHARS = 8;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 28;

    typedef enum logic [1:0] {ST_MATCH, ST_SKIP, ST_VALUE, ST_DONE} t_parse;

    typedef struct packed {
        fdec_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'd0;
    logic        i_end_of_body = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic        o_result_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [63:0] i_cfg_data = 64'd0;

    // predictor configuration and parse state
    logic [63:0] key_cfg = 64'd0;
    logic [3:0]  key_len_cfg = 4'd4;
    logic [7:0]  limit_cfg = 8'd32;
    t_parse      ph = ST_MATCH;
    logic [3:0]  key_pos = 4'd0;
    logic [1:0]  held_n = 2'd0;
    logic [7:0]  held_byte = 8'd0;
    logic [7:0]  emit_cnt = 8'd0;

    t_result     step_out[$];
    t_result     decoded_q[$];
    logic [7:0]  body_q[$];

    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    int          gap_max = 3;
    int          stall_pct = 30;
    int          stall_run = 0;
    logic        stall_on = 1'b0;
    string       hex_chars = "0123456789abcdefABCDEF";

    form_field_url_decoder_unit #(
        .KEY_MAX_CHARS(KEY_MAX_CHARS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_byte(i_in_byte),
        .i_end_of_body(i_end_of_body),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind(o_kind),
        .o_out_byte(o_out_byte),
        .o_result_last(o_result_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_run <= 0) begin
            stall_on = ($urandom_range(99) < stall_pct);
            stall_run = $urandom_range(1, stall_on ? 12 : 10);
        end
        stall_run--;
        i_out_stall <= stall_on;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: kind %0d byte %02h last %0b",
                             o_kind, o_out_byte, o_result_last);
            end else begin
                want = decoded_q.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.data ||
                    o_result_last !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: kind %0d/%0d byte %02h/%02h last %0b/%0b (exp/act)",
                                 want.kind, o_kind, want.data, o_out_byte,
                                 want.last, o_result_last);
                end
            end
        end
    end

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return fdec_pkg::HEX_NONE;
    endfunction

    function automatic logic [7:0] percent_value(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        ha = hex_digit(a);
        hb = hex_digit(b);
        if (ha != fdec_pkg::HEX_NONE)
            return (hb != fdec_pkg::HEX_NONE) ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
        if (a == fdec_pkg::CH_SPACE || (a >= 8'h09 && a <= 8'h0D) || a == fdec_pkg::CH_PLUS)
            return (hb != fdec_pkg::HEX_NONE) ? {4'd0, hb[3:0]} : 8'd0;
        if (a == fdec_pkg::CH_MINUS)
            return (hb != fdec_pkg::HEX_NONE) ? 8'd0 - {4'd0, hb[3:0]} : 8'd0;
        return 8'd0;
    endfunction

    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == fdec_pkg::CH_PLUS) ? fdec_pkg::CH_SPACE : c;
    endfunction

    function automatic bit out_full();
        return int'(emit_cnt) + 1 >= int'(limit_cfg);
    endfunction

    function automatic void emit(input fdec_pkg::t_kind k, input logic [7:0] b);
        step_out.push_back('{kind: k, data: b, last: 1'b0});
    endfunction

    function automatic void emit_value(input logic [7:0] b);
        if (!out_full()) begin
            emit(fdec_pkg::KIND_VALUE, b);
            emit_cnt++;
        end
    endfunction

    function automatic void finish_found();
        if (held_n >= 2'd1)
            emit_value(fdec_pkg::CH_PCT);
        if (held_n >= 2'd2)
            emit_value(plain(held_byte));
        held_n = 2'd0;
        held_byte = 8'd0;
        emit(fdec_pkg::KIND_FOUND, 8'd0);
        ph = ST_DONE;
    endfunction

    function automatic void decode_form_byte(input logic [7:0] c, input logic eob);
        int klen;
        t_result r;
        step_out.delete();
        klen = (key_len_cfg > KEY_MAX_CHARS) ? KEY_MAX_CHARS : key_len_cfg;
        case (ph)
            ST_MATCH: begin
                if (c == fdec_pkg::CH_AMP) begin
                    key_pos = 4'd0;
                end else if (key_pos < klen) begin
                    if (c == key_cfg[8*key_pos[2:0] +: 8])
                        key_pos++;
                    else
                        ph = ST_SKIP;
                end else if (c == fdec_pkg::CH_EQ) begin
                    ph = ST_VALUE;
                    emit_cnt = 8'd0;
                    held_n = 2'd0;
                    held_byte = 8'd0;
                    if (out_full())
                        finish_found();
                end else begin
                    ph = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (c == fdec_pkg::CH_AMP) begin
                    ph = ST_MATCH;
                    key_pos = 4'd0;
                end
            end
            ST_VALUE: begin
                if (c == fdec_pkg::CH_AMP) begin
                    finish_found();
                end else if (held_n == 2'd0) begin
                    if (c == fdec_pkg::CH_PCT)
                        held_n = 2'd1;
                    else
                        emit_value(plain(c));
                end else if (held_n == 2'd1) begin
                    held_n = 2'd2;
                    held_byte = c;
                end else begin
                    emit_value(percent_value(held_byte, c));
                    held_n = 2'd0;
                    held_byte = 8'd0;
                end
                if (ph == ST_VALUE && out_full())
                    finish_found();
            end
            default: ;
        endcase
        if (eob) begin
            if (ph == ST_VALUE)
                finish_found();
            else if (ph != ST_DONE)
                emit(fdec_pkg::KIND_ABSENT, 8'd0);
            ph = ST_MATCH;
            key_pos = 4'd0;
            held_n = 2'd0;
            held_byte = 8'd0;
            emit_cnt = 8'd0;
        end
        foreach (step_out[i]) begin
            r = step_out[i];
            r.last = (i == step_out.size() - 1);
            decoded_q.push_back(r);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eob);
        if (burst_left <= 0) begin
            if (gap_max > 0) begin
                if (i_in_valid)
                    i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_body <= eob;
        do @(posedge i_clk); while (o_in_stall);
        decode_form_byte(b, eob);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_body(input bit close);
        foreach (body_q[i])
            send_byte(body_q[i], close && (i == body_q.size() - 1));
    endtask

    task automatic send_text(input string s);
        body_q.delete();
        for (int i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
        send_body(1'b1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [63:0] key, input logic [3:0] len,
                                  input logic [7:0] limit);
        logic [1:0]  idx[3];
        logic [63:0] val[3];
        idx[0] = fdec_pkg::REG_KEY_CHARS;
        idx[1] = fdec_pkg::REG_KEY_LENGTH;
        idx[2] = fdec_pkg::REG_OUT_LIMIT;
        val[0] = key;
        val[1] = {60'd0, len};
        val[2] = {56'd0, limit};
        wait_drained();
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                fdec_pkg::REG_KEY_CHARS:  key_cfg = val[i];
                fdec_pkg::REG_KEY_LENGTH: key_len_cfg = val[i][3:0];
                fdec_pkg::REG_OUT_LIMIT:  limit_cfg = val[i][7:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // build one body: mostly well-formed segments, some pure noise
    task automatic make_body();
        int klen;
        int pick;
        int n;
        logic [7:0] lead;
        logic [7:0] key_b[$];
        body_q.delete();
        klen = (key_len_cfg > KEY_MAX_CHARS) ? KEY_MAX_CHARS : key_len_cfg;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(255)));
            return;
        end
        for (int s = 0; s < $urandom_range(1, 4); s++) begin
            if (s != 0)
                body_q.push_back(fdec_pkg::CH_AMP);
            key_b.delete();
            for (int i = 0; i < klen; i++)
                key_b.push_back(key_cfg[8*i +: 8]);
            pick = $urandom_range(9);
            if (pick inside {6, 7} && klen > 0)
                key_b[$urandom_range(klen - 1)] = 8'($urandom_range(255));
            else if (pick == 8)
                while (key_b.size() > $urandom_range(klen)) void'(key_b.pop_back());
            else if (pick == 9)
                key_b.push_back(8'($urandom_range(255)));
            foreach (key_b[i])
                body_q.push_back(key_b[i]);
            body_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                      : fdec_pkg::CH_EQ);
            n = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: body_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    4: body_q.push_back(fdec_pkg::CH_PLUS);
                    5, 6: begin
                        body_q.push_back(fdec_pkg::CH_PCT);
                        body_q.push_back(hex_chars[$urandom_range(21)]);
                        body_q.push_back(hex_chars[$urandom_range(21)]);
                    end
                    7: begin
                        case ($urandom_range(3))
                            0: lead = fdec_pkg::CH_SPACE;
                            1: lead = fdec_pkg::CH_PLUS;
                            2: lead = fdec_pkg::CH_MINUS;
                            default: lead = 8'(8'h09 + $urandom_range(4));
                        endcase
                        body_q.push_back(fdec_pkg::CH_PCT);
                        body_q.push_back(lead);
                        body_q.push_back(hex_chars[$urandom_range(21)]);
                    end
                    8: begin
                        body_q.push_back(fdec_pkg::CH_PCT);
                        body_q.push_back(8'($urandom_range(255)));
                        body_q.push_back(8'($urandom_range(255)));
                    end
                    default: body_q.push_back(8'($urandom_range(255)));
                endcase
            end
            // truncated escape at segment end
            if ($urandom_range(3) == 0) begin
                body_q.push_back(fdec_pkg::CH_PCT);
                if ($urandom_range(1))
                    body_q.push_back(($urandom_range(2) == 0) ? fdec_pkg::CH_PLUS
                                                              : hex_chars[$urandom_range(21)]);
            end
        end
    endtask

    task automatic run_random_phase(input logic [63:0] key, input logic [3:0] len,
                                    input logic [7:0] limit, input int stall, input int gap);
        int start;
        apply_settings(key, len, limit);
        stall_pct = stall;
        gap_max = gap;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            if ($urandom_range(14) == 0)
                wait_drained();
            make_body();
            send_body($urandom_range(5) != 0);
        end
    endtask

    task automatic test_reset_defaults();
        body_q = '{8'h00, 8'h00, 8'h00, 8'h00, fdec_pkg::CH_EQ, 8'hFF};
        send_body(1'b1);
    endtask

    task automatic test_percent_decoding();
        apply_settings({56'd0, 8'h6B}, 4'd1, 8'd32);
        send_text("k=%4A+%-1%");
    endtask

    task automatic test_segment_end_flush();
        send_text("q&k=% 5%g1%7&z");
    endtask

    task automatic test_random_bodies();
        logic [63:0] letters;
        for (int i = 0; i < 8; i++)
            letters[8*i +: 8] = 8'(8'h61 + $urandom_range(25));
        run_random_phase(letters, 4'd8, 8'd255, 0, 0);
        run_random_phase({$urandom, $urandom}, 4'd1, 8'd2, 30, 4);
        run_random_phase({64{1'b1}}, 4'd0, 8'd32, 50, 8);
        run_random_phase({$urandom, $urandom}, 4'd15, 8'd0, 20, 3);
        run_random_phase(letters, 4'd3, 8'd1, 40, 2);
        for (int i = 0; i < 8; i++)
            letters[8*i +: 8] = 8'(8'h41 + $urandom_range(25));
        run_random_phase(letters, 4'd5, 8'd5, 60, 6);
        run_random_phase(64'd0, 4'd2, 8'd20, 25, 5);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_percent_decoding();
        test_segment_end_flush();
        test_random_bodies();
        wait_drained();
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/fdec_pkg.sv
design/fdec_step.sv
design/fdec_out.sv
design/form_field_url_decoder_unit.sv
tb/tb.sv
